>>> rtl/tlbg_pkg.sv
// Widths, stage types and the divider lane type for the tetrahedron gradient core.
`default_nettype none
package tlbg_pkg;

  localparam int CW    = 32;            // coordinate width
  localparam int NV    = 4;             // vertices
  localparam int NC    = 3;             // components
  localparam int OW    = 32;            // gradient width
  localparam int DW    = CW + 1;        // edge difference
  localparam int PW    = 2 * DW;        // edge product
  localparam int NW    = PW + 1;        // normal component
  localparam int NLW   = 34;            // low slice of normal
  localparam int NHW   = NW - NLW;      // high slice of normal
  localparam int LPW   = DW + NLW + 1;  // low partial product
  localparam int HPW   = DW + NHW;      // high partial product
  localparam int DDW   = NW + DW + 2;   // triple product
  localparam int RW    = DDW + 1;       // divider remainder
  localparam int QW    = DW;            // quotient bits kept
  localparam int NSTEP = QW;            // divider steps
  localparam int NST   = NSTEP + 7;     // pipeline stages
  localparam int ITW   = NV * NC * CW;
  localparam int OTW   = NV * NC * OW;

  typedef logic signed [DW-1:0]  diff_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [NW-1:0]  norm_t;
  typedef logic signed [LPW-1:0] lpart_t;
  typedef logic signed [HPW-1:0] hpart_t;
  typedef logic signed [DDW-1:0] det_t;

  typedef struct packed {
    logic [DDW-1:0]           dmag;
    logic                     zero;
    logic [NC-1:0]            neg;
    logic [NC-1:0]            ovf;
    logic [NC-1:0]            nlsb;
    logic [NC-1:0][RW-1:0]    rem;
    logic [NC-1:0][QW-1:0]    quo;
  } lane_t;

endpackage
`default_nettype wire

>>> rtl/tet_linear_basis_gradient_core.sv
// Top level: pipelined gradient of the linear basis functions of a tetrahedron.
`default_nettype none
// Accepts one tetrahedron per cycle and returns its 3x4 basis gradient (Q16.16,
// truncated toward zero, saturated). Throughput is one item per cycle; most of
// the pipeline is the 33-stage restoring divider that forms n/d for each vertex,
// behind stages of differences, products, the triple product and divider setup.
// A vertex with zero triple product gives a zero gradient. The whole pipeline
// holds while a result waits on m_axis_tready.
module tet_linear_basis_gradient_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // x0,y0,z0,x1,y1,z1,x2,y2,z2,x3,y3,z3 (32 bits each, from bit 0 up)
  input  wire logic [tlbg_pkg::ITW-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // gx0,gy0,gz0,gx1,gy1,gz1,gx2,gy2,gz2,gx3,gy3,gz3 (32 bits each, from bit 0 up)
  output logic [tlbg_pkg::OTW-1:0]      m_axis_tdata
);

  logic en;
  logic [tlbg_pkg::NST-1:0] vld;

  tlbg_pkg::diff_t  u1 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::diff_t  v1 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::diff_t  w1 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::prod_t  pr2 [tlbg_pkg::NV][6];
  tlbg_pkg::diff_t  w2 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::norm_t  n3 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::diff_t  w3 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::hpart_t ph4 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::lpart_t pl4 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::norm_t  n4 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::det_t   d5 [tlbg_pkg::NV];
  tlbg_pkg::norm_t  n5 [tlbg_pkg::NV][tlbg_pkg::NC];
  tlbg_pkg::det_t   d_next [tlbg_pkg::NV];
  tlbg_pkg::lane_t  dv [tlbg_pkg::NSTEP+1][tlbg_pkg::NV];
  tlbg_pkg::lane_t  prep_next [tlbg_pkg::NV];
  logic [tlbg_pkg::OTW-1:0] tdata_next;

  function automatic tlbg_pkg::lane_t div_step(tlbg_pkg::lane_t ln, logic first);
    tlbg_pkg::lane_t r;
    logic [tlbg_pkg::RW-1:0] r2;
    r = ln;
    for (int c = 0; c < tlbg_pkg::NC; c++) begin
      r2 = {ln.rem[c][tlbg_pkg::RW-2:0], first & ln.nlsb[c]};
      if (r2 >= {1'b0, ln.dmag}) begin
        r.rem[c] = r2 - {1'b0, ln.dmag};
        r.quo[c] = {ln.quo[c][tlbg_pkg::QW-2:0], 1'b1};
      end else begin
        r.rem[c] = r2;
        r.quo[c] = {ln.quo[c][tlbg_pkg::QW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  assign en            = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[tlbg_pkg::NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[tlbg_pkg::NST-2:0], s_axis_tvalid};
    end
  end

  // edge differences
  always_ff @(posedge clk) begin
    int o, a, b;
    logic [tlbg_pkg::CW-1:0] pi, po, pa, pb;
    if (en) begin
      for (int i = 0; i < tlbg_pkg::NV; i++) begin
        o = (i + 1) % tlbg_pkg::NV;
        a = (i + 2) % tlbg_pkg::NV;
        b = (i + 3) % tlbg_pkg::NV;
        for (int c = 0; c < tlbg_pkg::NC; c++) begin
          pi = s_axis_tdata[(i*tlbg_pkg::NC+c)*tlbg_pkg::CW +: tlbg_pkg::CW];
          po = s_axis_tdata[(o*tlbg_pkg::NC+c)*tlbg_pkg::CW +: tlbg_pkg::CW];
          pa = s_axis_tdata[(a*tlbg_pkg::NC+c)*tlbg_pkg::CW +: tlbg_pkg::CW];
          pb = s_axis_tdata[(b*tlbg_pkg::NC+c)*tlbg_pkg::CW +: tlbg_pkg::CW];
          u1[i][c] <= {pa[tlbg_pkg::CW-1], pa} - {po[tlbg_pkg::CW-1], po};
          v1[i][c] <= {pb[tlbg_pkg::CW-1], pb} - {po[tlbg_pkg::CW-1], po};
          w1[i][c] <= {pi[tlbg_pkg::CW-1], pi} - {po[tlbg_pkg::CW-1], po};
        end
      end
    end
  end

  // cross product terms, normal, triple product partials
  always_ff @(posedge clk) begin
    logic signed [tlbg_pkg::NHW-1:0] nh;
    logic signed [tlbg_pkg::NLW:0]   nl;
    if (en) begin
      for (int i = 0; i < tlbg_pkg::NV; i++) begin
        pr2[i][0] <= u1[i][1] * v1[i][2];
        pr2[i][1] <= u1[i][2] * v1[i][1];
        pr2[i][2] <= u1[i][2] * v1[i][0];
        pr2[i][3] <= u1[i][0] * v1[i][2];
        pr2[i][4] <= u1[i][0] * v1[i][1];
        pr2[i][5] <= u1[i][1] * v1[i][0];
        for (int c = 0; c < tlbg_pkg::NC; c++) begin
          w2[i][c] <= w1[i][c];
          n3[i][c] <= {pr2[i][2*c][tlbg_pkg::PW-1], pr2[i][2*c]}
                    - {pr2[i][2*c+1][tlbg_pkg::PW-1], pr2[i][2*c+1]};
          w3[i][c] <= w2[i][c];
          nh = n3[i][c][tlbg_pkg::NW-1:tlbg_pkg::NLW];
          nl = {1'b0, n3[i][c][tlbg_pkg::NLW-1:0]};
          ph4[i][c] <= w3[i][c] * nh;
          pl4[i][c] <= w3[i][c] * nl;
          n4[i][c]  <= n3[i][c];
          n5[i][c]  <= n4[i][c];
        end
        d5[i] <= d_next[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < tlbg_pkg::NV; i++) begin
      d_next[i] = '0;
      for (int c = 0; c < tlbg_pkg::NC; c++) begin
        d_next[i] = d_next[i] + (tlbg_pkg::det_t'(ph4[i][c]) <<< tlbg_pkg::NLW)
                  + tlbg_pkg::det_t'(pl4[i][c]);
      end
    end
  end

  // divider setup: magnitudes, sign, overflow of the high quotient bits
  always_comb begin
    logic [tlbg_pkg::NW-1:0] nmag;
    for (int i = 0; i < tlbg_pkg::NV; i++) begin
      prep_next[i]      = '0;
      prep_next[i].dmag = d5[i][tlbg_pkg::DDW-1] ? -d5[i] : d5[i];
      prep_next[i].zero = (d5[i] == '0);
      for (int c = 0; c < tlbg_pkg::NC; c++) begin
        nmag = n5[i][c][tlbg_pkg::NW-1] ? -n5[i][c] : n5[i][c];
        prep_next[i].neg[c]  = n5[i][c][tlbg_pkg::NW-1] ^ d5[i][tlbg_pkg::DDW-1];
        prep_next[i].nlsb[c] = nmag[0];
        prep_next[i].rem[c]  = tlbg_pkg::RW'(nmag >> 1);
        prep_next[i].ovf[c]  = tlbg_pkg::RW'(nmag >> 1) >= {1'b0, prep_next[i].dmag};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tlbg_pkg::NV; i++) begin
        dv[0][i] <= prep_next[i];
        for (int k = 0; k < tlbg_pkg::NSTEP; k++) begin
          dv[k+1][i] <= div_step(dv[k][i], k == 0);
        end
      end
    end
  end

  // saturation and sign
  always_comb begin
    logic [tlbg_pkg::QW-1:0] lim, mag, val;
    tlbg_pkg::lane_t ln;
    for (int i = 0; i < tlbg_pkg::NV; i++) begin
      ln = dv[tlbg_pkg::NSTEP][i];
      for (int c = 0; c < tlbg_pkg::NC; c++) begin
        lim = ln.neg[c] ? (tlbg_pkg::QW'(1) << (tlbg_pkg::OW-1))
                        : ((tlbg_pkg::QW'(1) << (tlbg_pkg::OW-1)) - tlbg_pkg::QW'(1));
        mag = (ln.ovf[c] || ln.quo[c] > lim) ? lim : ln.quo[c];
        val = ln.zero ? '0 : (ln.neg[c] ? -mag : mag);
        tdata_next[(i*tlbg_pkg::NC+c)*tlbg_pkg::OW +: tlbg_pkg::OW] = val[tlbg_pkg::OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= tdata_next;
    end
  end

  a_rst_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline stalled");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    vld[6] && !dv[1][0].zero && !dv[1][0].ovf[0]
    |-> dv[1][0].rem[0] < {1'b0, dv[1][0].dmag})
    else $error("divider remainder out of range");

  a_zero_det: assert property (@(posedge clk) disable iff (rst)
    en && vld[tlbg_pkg::NST-2] && dv[tlbg_pkg::NSTEP][0].zero
    |=> m_axis_tdata[tlbg_pkg::NC*tlbg_pkg::OW-1:0] == '0)
    else $error("degenerate vertex gave nonzero gradient");

endmodule
`default_nettype wire

>>> verif/tet_linear_basis_gradient_core_tb.sv
// Testbench for the tetrahedron basis gradient core: directed and random stream checks.
`default_nettype none
module tet_linear_basis_gradient_core_tb;

  typedef logic signed [255:0] wide_t;
  typedef logic [tlbg_pkg::ITW-1:0] tet_t;
  typedef logic [tlbg_pkg::OTW-1:0] grad_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  s_axis_tvalid = 1'b0;
  logic  s_axis_tready;
  tet_t  s_axis_tdata = '0;
  logic  m_axis_tvalid;
  logic  m_axis_tready = 1'b0;
  grad_t m_axis_tdata;

  tet_t  tet_queue[$];
  grad_t grad_expected[$];
  int    errors = 0;
  int    n_sent = 0;
  int    n_checked = 0;
  int    burst_left = 0;
  int    gap_left = 0;
  int    stall_mode = 0;
  int    mode_left = 0;

  always #2 clk = ~clk;

  tet_linear_basis_gradient_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // n = u x v, d = (V[i]-O).n, gradient = trunc(n * 2^32 / d), saturated
  function automatic grad_t basis_gradient(tet_t t);
    wide_t p[4][3];
    wide_t u[3], v[3], w[3], n[3];
    wide_t d, q;
    grad_t g;
    int o, a, b;
    g = '0;
    for (int i = 0; i < 4; i++)
      for (int c = 0; c < 3; c++)
        p[i][c] = wide_t'($signed(t[(i*3+c)*tlbg_pkg::CW +: tlbg_pkg::CW]));
    for (int i = 0; i < 4; i++) begin
      o = (i + 1) % 4; a = (i + 2) % 4; b = (i + 3) % 4;
      for (int c = 0; c < 3; c++) begin
        u[c] = p[a][c] - p[o][c];
        v[c] = p[b][c] - p[o][c];
        w[c] = p[i][c] - p[o][c];
      end
      n[0] = u[1]*v[2] - u[2]*v[1];
      n[1] = u[2]*v[0] - u[0]*v[2];
      n[2] = u[0]*v[1] - u[1]*v[0];
      d = w[0]*n[0] + w[1]*n[1] + w[2]*n[2];
      for (int c = 0; c < 3; c++) begin
        if (d == 0) q = 0;
        else begin
          q = (n[c] <<< 32) / d;
          if (q > wide_t'(32'sh7FFFFFFF)) q = wide_t'(32'sh7FFFFFFF);
          else if (q < -wide_t'(64'sh80000000)) q = -wide_t'(64'sh80000000);
        end
        g[(i*3+c)*tlbg_pkg::OW +: tlbg_pkg::OW] = q[tlbg_pkg::OW-1:0];
      end
    end
    return g;
  endfunction

  function automatic tet_t make_tet(int lo, int hi);
    tet_t t;
    for (int k = 0; k < tlbg_pkg::NV*tlbg_pkg::NC; k++)
      t[k*tlbg_pkg::CW +: tlbg_pkg::CW] = $urandom_range(hi - lo) + lo;
    return t;
  endfunction

  function automatic tet_t full_random_tet();
    tet_t t;
    for (int k = 0; k < tlbg_pkg::NV*tlbg_pkg::NC; k++)
      t[k*tlbg_pkg::CW +: tlbg_pkg::CW] = $urandom;
    return t;
  endfunction

  function automatic tet_t from_ints(int c[12]);
    tet_t t;
    for (int k = 0; k < 12; k++) t[k*tlbg_pkg::CW +: tlbg_pkg::CW] = c[k];
    return t;
  endfunction

  task automatic add_tet(tet_t t);
    tet_queue.insert(tet_queue.size(), t);
  endtask

  // driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        grad_expected.insert(grad_expected.size(), basis_gradient(s_axis_tdata));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tet_queue.size() > 0) begin
          s_axis_tdata  <= tet_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(30, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stall pattern changes every so often
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (grad_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction: %h", m_axis_tdata);
        end else begin
          grad_t e;
          e = grad_expected.pop_front();
          n_checked++;
          for (int k = 0; k < tlbg_pkg::NV*tlbg_pkg::NC; k++)
            if (m_axis_tdata[k*tlbg_pkg::OW +: tlbg_pkg::OW]
                !== e[k*tlbg_pkg::OW +: tlbg_pkg::OW]) begin
              errors++;
              if (errors <= 10)
                $display("mismatch result %0d field %0d: expected %h actual %h",
                         n_checked, k, e[k*tlbg_pkg::OW +: tlbg_pkg::OW],
                         m_axis_tdata[k*tlbg_pkg::OW +: tlbg_pkg::OW]);
            end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(2);
        mode_left  = $urandom_range(80, 10);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(9) < 7);
        default: m_axis_tready <= ($urandom_range(9) == 0);
      endcase
    end
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    tet_t t;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // all zero: every vertex degenerate
    add_tet('0);
    // unit tetrahedron and its mirror
    add_tet(from_ints('{0,0,0, 65536,0,0, 0,65536,0, 0,0,65536}));
    add_tet(from_ints('{0,0,0, 0,65536,0, 65536,0,0, 0,0,65536}));
    // one LSB edges: gradients saturate
    add_tet(from_ints('{0,0,0, 1,0,0, 0,1,0, 0,0,1}));
    add_tet(from_ints('{0,0,0, -1,0,0, 0,-1,0, 0,0,-1}));
    // coordinate extremes
    add_tet(from_ints('{32'h80000000,32'h80000000,32'h80000000,
                        32'h7FFFFFFF,32'h80000000,32'h80000000,
                        32'h80000000,32'h7FFFFFFF,32'h80000000,
                        32'h80000000,32'h80000000,32'h7FFFFFFF}));
    add_tet(from_ints('{32'h7FFFFFFF,32'h7FFFFFFF,32'h7FFFFFFF,
                        32'h80000000,32'h7FFFFFFF,32'h7FFFFFFF,
                        32'h7FFFFFFF,32'h80000000,32'h7FFFFFFF,
                        32'h7FFFFFFF,32'h7FFFFFFF,32'h80000000}));
    add_tet({(tlbg_pkg::NV*tlbg_pkg::NC){32'hFFFFFFFF}});
    add_tet({(tlbg_pkg::NV*tlbg_pkg::NC){32'h80000000}});
    add_tet({(tlbg_pkg::NV*tlbg_pkg::NC/2){32'h7FFFFFFF, 32'h80000000}});
    // coplanar vertices, zero-area face, coincident vertices
    add_tet(from_ints('{0,0,0, 65536,0,0, 0,65536,0, 65536,65536,0}));
    add_tet(from_ints('{0,0,0, 65536,0,0, 131072,0,0, 0,0,65536}));
    add_tet(from_ints('{5,6,7, 5,6,7, 0,65536,0, 0,0,65536}));
    // a thin tetrahedron near saturation and a half-size unit tetrahedron
    add_tet(from_ints('{0,0,0, 65536,0,0, 0,65536,0, 0,0,2}));
    add_tet(from_ints('{0,0,0, 32768,0,0, 0,32768,0, 0,0,32768}));
    for (int k = 0; k < 5; k++) add_tet(full_random_tet());
    for (int k = 0; k < 400; k++) begin
      case ($urandom_range(9))
        0, 1, 2: t = full_random_tet();
        3, 4, 5: t = make_tet(-(1 << 20), 1 << 20);
        6:       t = make_tet(-256, 256);
        7:       t = make_tet(-4, 4);
        8: begin
          t = make_tet(-(1 << 18), 1 << 18);
          t[3*tlbg_pkg::CW +: 3*tlbg_pkg::CW] = t[0 +: 3*tlbg_pkg::CW];
        end
        default: begin
          t = make_tet(-(1 << 16), 1 << 16);
          t[11*tlbg_pkg::CW +: tlbg_pkg::CW] = t[5*tlbg_pkg::CW +: tlbg_pkg::CW];
          t[8*tlbg_pkg::CW +: tlbg_pkg::CW]  = t[5*tlbg_pkg::CW +: tlbg_pkg::CW];
          t[2*tlbg_pkg::CW +: tlbg_pkg::CW]  = t[5*tlbg_pkg::CW +: tlbg_pkg::CW];
        end
      endcase
      add_tet(t);
    end
    wait (tet_queue.size() == 0 && !s_axis_tvalid);
    wait (grad_expected.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d tetrahedra: extremes, saturation, degenerate faces", n_sent);
    $display("random bursts and receiver stalls, %0d results checked", n_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
